FILE: src/sle_pkg.sv
`default_nettype none

package sle_pkg;

  // default depth of the sorted store
  localparam int unsigned CAPACITY = 64;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_BACK   = 3'd3;
  localparam logic [2:0] OP_FWD    = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // command transaction
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] cursor_value;
    logic               cursor_valid;
    logic [6:0]         entry_count;
  } out_t;

endpackage

`default_nettype wire

FILE: src/sle_store.sv
`default_nettype none

module sle_store #(
  parameter int unsigned DEPTH = sle_pkg::CAPACITY,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic signed [31:0]   wdata_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic signed [31:0]        rdata_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/sle_seq.sv
`default_nettype none

module sle_seq #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire sle_pkg::in_t       item_i,
  output logic                    busy_o,
  output logic                    done_o,
  output sle_pkg::out_t           result_o,
  output logic                    we_o,
  output logic [AW-1:0]           waddr_o,
  output logic signed [31:0]      wdata_o,
  output logic [AW-1:0]           raddr_o,
  input  wire logic signed [31:0] rdata_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CHK = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_PLACE    = 3'd5;
  localparam logic [2:0] S_OUT_RD   = 3'd6;
  localparam logic [2:0] S_OUT_CHK  = 3'd7;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [2:0]         state_q;
  logic [2:0]         op_q;
  logic signed [31:0] val_q;
  logic               past_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      cur_q;
  logic [CW-1:0]      i_q;
  logic [CW-1:0]      k_q;
  logic [1:0]         status_q;
  logic               done_q;
  sle_pkg::out_t      res_q;

  logic [CW-1:0] km1;
  logic [CW-1:0] kp1;
  logic          is_ins;
  logic          val_lt;
  logic          val_eq;
  logic          hit;
  logic          cur_ok;

  assign km1    = k_q - 1'b1;
  assign kp1    = k_q + 1'b1;
  assign is_ins = (op_q == sle_pkg::OP_INSERT);
  assign cur_ok = (cur_q < count_q);

  // shared compare unit: stored word against the operand
  assign val_lt = (rdata_i < val_q);
  assign val_eq = (rdata_i == val_q);
  assign hit    = is_ins ? !val_lt : val_eq;

  // store port control
  always_comb begin
    raddr_o = cur_q[AW-1:0];
    we_o    = 1'b0;
    waddr_o = k_q[AW-1:0];
    wdata_o = rdata_i;
    unique case (state_q)
      S_SCAN_RD: begin
        raddr_o = i_q[AW-1:0];
      end
      S_SHIFT_RD: begin
        raddr_o = is_ins ? km1[AW-1:0] : kp1[AW-1:0];
      end
      S_SHIFT_WR: begin
        we_o = 1'b1;
      end
      S_PLACE: begin
        we_o    = 1'b1;
        waddr_o = i_q[AW-1:0];
        wdata_o = val_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cur_q    <= '0;
      done_q   <= 1'b0;
      op_q     <= sle_pkg::OP_READ;
      val_q    <= '0;
      past_q   <= 1'b0;
      i_q      <= '0;
      k_q      <= '0;
      status_q <= sle_pkg::ST_OK;
      res_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q     <= item_i.op;
            val_q    <= item_i.value;
            past_q   <= !cur_ok;
            i_q      <= '0;
            status_q <= sle_pkg::ST_OK;
            state_q  <= S_OUT_RD;
            unique case (item_i.op)
              sle_pkg::OP_INSERT: begin
                if (count_q >= CAP_C) begin
                  status_q <= sle_pkg::ST_FULL;
                end else begin
                  state_q <= S_SCAN_RD;
                end
              end
              sle_pkg::OP_DELETE: begin
                if (count_q == '0) begin
                  status_q <= sle_pkg::ST_EMPTY;
                end else begin
                  state_q <= S_SCAN_RD;
                end
              end
              sle_pkg::OP_START: begin
                cur_q <= '0;
              end
              sle_pkg::OP_BACK: begin
                if (cur_ok && (cur_q != '0)) begin
                  cur_q <= cur_q - 1'b1;
                end
              end
              sle_pkg::OP_FWD: begin
                if (cur_ok) begin
                  cur_q <= cur_q + 1'b1;
                end
              end
              sle_pkg::OP_CLEAR: begin
                count_q <= '0;
                cur_q   <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          if (i_q == count_q) begin
            if (is_ins) begin
              k_q     <= count_q;
              state_q <= S_SHIFT_RD;
            end else begin
              status_q <= sle_pkg::ST_NOTFOUND;
              state_q  <= S_OUT_RD;
            end
          end else begin
            state_q <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (hit) begin
            k_q     <= is_ins ? count_q : i_q;
            state_q <= S_SHIFT_RD;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          if (is_ins) begin
            state_q <= (k_q == i_q) ? S_PLACE : S_SHIFT_WR;
          end else if (kp1 >= count_q) begin
            // delete done: drop the count and fix the cursor
            count_q <= count_q - 1'b1;
            if (past_q) begin
              cur_q <= count_q - 1'b1;
            end else if (cur_q > i_q) begin
              cur_q <= cur_q - 1'b1;
            end
            state_q <= S_OUT_RD;
          end else begin
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          k_q     <= is_ins ? km1 : kp1;
          state_q <= S_SHIFT_RD;
        end
        S_PLACE: begin
          count_q <= count_q + 1'b1;
          if (past_q) begin
            cur_q <= count_q + 1'b1;
          end else if (cur_q >= i_q) begin
            cur_q <= cur_q + 1'b1;
          end
          state_q <= S_OUT_RD;
        end
        S_OUT_RD: begin
          state_q <= S_OUT_CHK;
        end
        S_OUT_CHK: begin
          res_q.status       <= status_q;
          res_q.cursor_valid <= cur_ok;
          res_q.cursor_value <= cur_ok ? rdata_i : 32'sd0;
          res_q.entry_count  <= 7'(count_q);
          done_q             <= 1'b1;
          state_q            <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

FILE: src/sorted_list_engine_unit.sv
`default_nettype none

// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending
// order, with a cursor, in a single-port-read store. A command is taken when
// start_i is high and busy_o is low; exactly one result follows, shown for one
// cycle with done_o high, and the receiver cannot stall it. All entries sit in
// one memory with one read and one write port, so the work walks that port one
// entry at a time: cursor moves, read and clear only read the cursor entry for
// the result; an insert scans for its position, shifts the later entries up
// and places the value, and a delete scans for its match and, if found, shifts
// the later entries down. The next command may be issued in the cycle the
// result is shown. The store needs no clearing after reset.
module sorted_list_engine_unit #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire sle_pkg::in_t item_i,
  output logic              busy_o,
  output logic              done_o,
  output sle_pkg::out_t     result_o
);

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rdata;

  // sequencer with the shared compare unit
  sle_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  // entry store
  sle_store #(
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

`default_nettype wire

FILE: src/sle_checker.sv
`default_nettype none

module sle_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_o,
  input wire logic          done_o,
  input wire sle_pkg::out_t result_o
);

  // an accepted transaction makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted transaction");

  // busy drops exactly when the result appears
  a_done_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // an invalid cursor reads as zero
  a_cursor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.cursor_valid) |-> (result_o.cursor_value == 32'sd0))
    else $error("invalid cursor with nonzero value");

  // full status only with a full store
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == sle_pkg::ST_FULL)) |->
      (result_o.entry_count == 7'(sle_pkg::CAPACITY)))
    else $error("full status with room left");

  // an empty list never has a valid cursor
  a_empty_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.entry_count == 7'd0)) |-> !result_o.cursor_valid)
    else $error("valid cursor on empty list");

endmodule

bind sorted_list_engine_unit sle_checker u_sle_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .result_o(result_o)
);

`default_nettype wire

FILE: tb/sv/tb_sorted_list_engine_unit.sv
`default_nettype none

module tb_sorted_list_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = sle_pkg::CAPACITY;
  // op code with no function; the block must leave everything unchanged
  localparam logic [2:0] OP_UNUSED = 3'd7;
  // worst insert walk plus margin
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 40;
  localparam int unsigned RANDOM_ITEMS = 1700;

  // ordered store tracker: mirrors the list and queues the expected results
  class sorted_list_tracker;
    logic signed [31:0] entries [DEPTH];
    int unsigned fill;
    int unsigned cursor;
    sle_pkg::out_t expected_results [$];
    int unsigned errors;
    int unsigned commands;
    int unsigned results;
    int unsigned full_hits;
    int unsigned empty_hits;
    int unsigned miss_hits;
    int unsigned peak_fill;

    function new();
      fill = 0;
      cursor = 0;
      errors = 0;
      commands = 0;
      results = 0;
      full_hits = 0;
      empty_hits = 0;
      miss_hits = 0;
      peak_fill = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    task flag(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // apply one command to the mirror and return what the block should report
    function sle_pkg::out_t apply_command(sle_pkg::in_t cmd);
      sle_pkg::out_t r;
      logic [1:0] st;
      logic signed [31:0] v;
      int unsigned pos;
      int unsigned k;
      bit past;
      st = sle_pkg::ST_OK;
      v = cmd.value;
      past = (cursor >= fill);
      case (cmd.op)
        sle_pkg::OP_INSERT: begin
          if (fill >= DEPTH) begin
            st = sle_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < fill && entries[pos] < v) pos++;
            for (k = fill; k > pos; k--) entries[k] = entries[k - 1];
            entries[pos] = v;
            if (past) cursor = fill + 1;
            else if (cursor >= pos) cursor++;
            fill++;
          end
        end
        sle_pkg::OP_DELETE: begin
          if (fill == 0) begin
            st = sle_pkg::ST_EMPTY;
          end else begin
            pos = 0;
            while (pos < fill && entries[pos] != v) pos++;
            if (pos >= fill) begin
              st = sle_pkg::ST_NOTFOUND;
            end else begin
              for (k = pos; k + 1 < fill; k++) entries[k] = entries[k + 1];
              fill--;
              if (past) cursor = fill;
              else if (cursor > pos) cursor--;
              if (cursor > fill) cursor = fill;
            end
          end
        end
        sle_pkg::OP_START: cursor = 0;
        sle_pkg::OP_BACK: begin
          if (cursor < fill && cursor > 0) cursor--;
        end
        sle_pkg::OP_FWD: begin
          if (cursor < fill) cursor++;
        end
        sle_pkg::OP_CLEAR: begin
          fill = 0;
          cursor = 0;
        end
        default: ;
      endcase
      r.status = st;
      r.cursor_valid = (cursor < fill);
      r.cursor_value = (cursor < fill) ? entries[cursor] : '0;
      r.entry_count = fill[6:0];
      return r;
    endfunction

    function void note_command(sle_pkg::in_t cmd);
      sle_pkg::out_t r;
      r = apply_command(cmd);
      expected_results.push_back(r);
      commands++;
      if (fill > peak_fill) peak_fill = fill;
      if (r.status == sle_pkg::ST_FULL) full_hits++;
      if (r.status == sle_pkg::ST_EMPTY) empty_hits++;
      if (r.status == sle_pkg::ST_NOTFOUND) miss_hits++;
    endfunction

    task check_result(sle_pkg::out_t got);
      sle_pkg::out_t want;
      if (expected_results.size() == 0) begin
        flag("result with no command outstanding");
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          flag($sformatf("result %0d status got %0d want %0d",
                         results, got.status, want.status));
        if (got.cursor_valid !== want.cursor_valid)
          flag($sformatf("result %0d cursor_valid got %0b want %0b",
                         results, got.cursor_valid, want.cursor_valid));
        if (got.cursor_value !== want.cursor_value)
          flag($sformatf("result %0d cursor_value got %0d want %0d",
                         results, got.cursor_value, want.cursor_value));
        if (got.entry_count !== want.entry_count)
          flag($sformatf("result %0d entry_count got %0d want %0d",
                         results, got.entry_count, want.entry_count));
      end
      results++;
    endtask
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  sle_pkg::in_t   item_i;
  logic           busy_o;
  logic           done_o;
  sle_pkg::out_t  result_o;

  sorted_list_tracker sb = new();
  int unsigned idle_pct;
  int unsigned sent;

  sorted_list_engine_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

  // monitor: result first, since a new command may be taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(result_o);
      if (start_i && !busy_o) sb.note_command(item_i);
    end
  end

  // hold a command until the block takes it
  task send_command(input logic [2:0] op, input logic signed [31:0] value);
    sle_pkg::in_t cmd;
    cmd.op = op;
    cmd.value = value;
    item_i <= cmd;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sent++;
  endtask

  // one idle cycle with junk on the payload
  task idle_cycle();
    sle_pkg::in_t junk;
    junk.op = 3'($urandom);
    junk.value = $urandom;
    start_i <= 1'b0;
    item_i <= junk;
    @(posedge clk_i);
  endtask

  // random gap after a transaction
  task sender_gap();
    while ($urandom_range(99) < idle_pct) idle_cycle();
  endtask

  // stop sending until the block has answered everything
  task drain();
    idle_cycle();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task issue(input logic [2:0] op, input logic signed [31:0] value);
    send_command(op, value);
    sender_gap();
  endtask

  // operand mix: dense small values for duplicates, extremes, full range
  function logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      return 32'($signed($urandom_range(16)) - 8);
    end else if (sel < 55) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7fff_ffff;
        3: return 32'sh7fff_fffe;
        4: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end else begin
      return $urandom;
    end
  endfunction

  // delete operand: mostly a value that is stored
  function logic signed [31:0] pick_victim();
    if (sb.fill > 0 && $urandom_range(99) < 70)
      return sb.entries[$urandom_range(sb.fill - 1)];
    return pick_value();
  endfunction

  task directed_run();
    issue(sle_pkg::OP_DELETE, 32'sd5);
    issue(sle_pkg::OP_FWD, 32'sd0);
    issue(sle_pkg::OP_BACK, 32'sd0);
    issue(sle_pkg::OP_START, 32'sd0);
    issue(sle_pkg::OP_READ, 32'sd0);
    issue(sle_pkg::OP_INSERT, 32'sd0);
    issue(sle_pkg::OP_INSERT, 32'sd0);
    issue(sle_pkg::OP_INSERT, 32'sh7fff_ffff);
    issue(sle_pkg::OP_INSERT, 32'sh8000_0000);
    issue(sle_pkg::OP_INSERT, -32'sd1);
    issue(sle_pkg::OP_START, 32'sd0);
    issue(sle_pkg::OP_BACK, 32'sd0);
    issue(sle_pkg::OP_FWD, 32'sd0);
    issue(sle_pkg::OP_DELETE, 32'sh8000_0000);
    issue(sle_pkg::OP_INSERT, 32'sh8000_0000);
    issue(sle_pkg::OP_DELETE, 32'sd12345);
    repeat (4) issue(sle_pkg::OP_FWD, 32'sd0);
    issue(sle_pkg::OP_BACK, 32'sd0);
    issue(sle_pkg::OP_INSERT, 32'sd7);
    issue(sle_pkg::OP_START, 32'sd0);
    issue(sle_pkg::OP_DELETE, 32'sh8000_0000);
    issue(OP_UNUSED, 32'shffff_ffff);
    issue(sle_pkg::OP_CLEAR, 32'sh5555_aaaa);
  endtask

  // one burst of related commands
  task run_burst();
    int unsigned kind;
    int unsigned len;
    int unsigned sel;
    kind = $urandom_range(9);
    len = $urandom_range(40, 5);
    if (kind <= 2) begin
      // fill toward full, with some cursor traffic
      len = $urandom_range(80, 1);
      repeat (len) begin
        sel = $urandom_range(9);
        if (sel < 8) issue(sle_pkg::OP_INSERT, pick_value());
        else if (sel == 8) issue(sle_pkg::OP_FWD, pick_value());
        else issue(sle_pkg::OP_START, pick_value());
      end
    end else if (kind <= 4) begin
      // drain, mostly hitting stored values
      repeat (len) begin
        if ($urandom_range(9) < 8) issue(sle_pkg::OP_DELETE, pick_victim());
        else issue(sle_pkg::OP_READ, pick_value());
      end
    end else if (kind <= 6) begin
      // cursor walk with edits around it
      issue(sle_pkg::OP_START, pick_value());
      repeat (len) begin
        sel = $urandom_range(9);
        if (sel < 4) issue(sle_pkg::OP_FWD, pick_value());
        else if (sel < 6) issue(sle_pkg::OP_BACK, pick_value());
        else if (sel < 7) issue(sle_pkg::OP_READ, pick_value());
        else if (sel < 8) issue(sle_pkg::OP_INSERT, pick_value());
        else issue(sle_pkg::OP_DELETE, pick_victim());
      end
    end else if (kind <= 8) begin
      // any op, including the unused code
      repeat (len) begin
        sel = $urandom_range(7);
        if (sel == sle_pkg::OP_DELETE) issue(3'(sel), pick_victim());
        else if (sel == sle_pkg::OP_CLEAR && $urandom_range(3) != 0)
          issue(sle_pkg::OP_READ, pick_value());
        else issue(3'(sel), pick_value());
      end
    end else begin
      issue(sle_pkg::OP_CLEAR, pick_value());
      repeat ($urandom_range(6, 1)) issue(sle_pkg::OP_INSERT, pick_value());
    end
    if ($urandom_range(19) == 0) drain();
  endtask

  // main sequence
  initial begin
    int unsigned phase;
    int unsigned target;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    sent = 0;
    idle_pct = 36;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_run();
    drain();

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 36 : (phase == 1) ? 52 : 0;
      target = sent + RANDOM_ITEMS / 3;
      // open the first phase by filling past capacity
      if (phase == 0) repeat (DEPTH + 6) issue(sle_pkg::OP_INSERT, pick_value());
      while (sent < target) run_burst();
      drain();
    end

    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.flag("commands left without a result");

    $display("covered %0d commands and %0d results, peak fill %0d of %0d",
             sb.commands, sb.results, sb.peak_fill, DEPTH);
    $display("status cases seen: full %0d, empty %0d, not found %0d",
             sb.full_hits, sb.empty_hits, sb.miss_hits);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
